// ===== rtl/audio_mix_bus_with_fades_and_meters_top_assert.svh =====
// ----------------------------------------------------------------------------
// mix bus assertion macros
// shared property forms for the mix bus checker
// ----------------------------------------------------------------------------
`ifndef AUDIO_MIX_BUS_WITH_FADES_AND_METERS_TOP_ASSERT_SVH
`define AUDIO_MIX_BUS_WITH_FADES_AND_METERS_TOP_ASSERT_SVH

// same-cycle implication
`define AMB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/amb_pkg.sv =====
// ----------------------------------------------------------------------------
// mix bus package
// shared constants, types and helper functions for the mix bus
// ----------------------------------------------------------------------------
package amb_pkg;

   localparam int MAX_FRAMES   = 4096;
   localparam int MAX_CHANNELS = 8;
   localparam int FRAME_W      = 12;
   localparam int CH_W         = 3;
   localparam int ADDR_W       = FRAME_W + CH_W;
   localparam int BUF_DEPTH    = 2 ** ADDR_W;
   localparam int BUF_W        = 32;
   localparam int TANH_BINS    = 512;
   localparam int TANH_AW      = 9;
   localparam int FADE_STEPS   = 8;
   localparam int RMS_STEPS    = 32;
   localparam int SQRT_STEPS   = 32;
   localparam int CNT_W        = 6;
   localparam int REG_IDX_W    = 2;
   localparam int CSR_W        = 16;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_ACC    = 2'd1,
      OP_READ   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_CHANNEL_COUNT  = 2'd0,
      REG_FRAME_COUNT    = 2'd1,
      REG_MASTER_GAIN    = 2'd2,
      REG_LIMITER_ENABLE = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [23:0] rem;
      logic [63:0] quo;
   } div_state_type;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] one;
   } sqrt_state_type;

   typedef logic [15:0] tanh_rom_type [TANH_BINS];

   function automatic logic [3:0] eff_channels(input logic [3:0] cc);
      logic [3:0] res;
      if (cc == 4'd0) res = 4'd1;
      else if (cc > 4'(MAX_CHANNELS)) res = 4'(MAX_CHANNELS);
      else res = cc;
      return res;
   endfunction

   function automatic logic [12:0] eff_frames(input logic [12:0] fc);
      logic [12:0] res;
      if (fc == 13'd0) res = 13'd1;
      else if (fc > 13'(MAX_FRAMES)) res = 13'(MAX_FRAMES);
      else res = fc;
      return res;
   endfunction

   // restoring long division for the table constants
   function automatic logic [127:0] const_div(input logic [127:0] dvd,
                                              input logic [127:0] dvs);
      logic [127:0] quo;
      logic [127:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 127; i >= 0; i--) begin
         rem = {rem[126:0], dvd[i]};
         if (rem >= dvs) begin
            rem    = rem - dvs;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(32767 * tanh(k / 64)) built from a series for e^(-1/32)
   function automatic tanh_rom_type build_tanh();
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  stp;
      logic [63:0]  e;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] prod;
      tanh_rom_type rom;
      term = 64'd1 << 60;
      sum  = 64'd1 << 60;
      for (int n = 1; n < 12; n++) begin
         term = 64'(const_div({64'd0, term}, {64'd0, 64'd32 * 64'(n)}));
         if (n[0]) sum = sum - term;
         else sum = sum + term;
      end
      stp = (sum + (64'd1 << 27)) >> 28;
      e   = 64'd1 << 32;
      for (int k = 0; k < TANH_BINS; k++) begin
         num    = 128'd32767 * ((128'd1 << 32) - {64'd0, e});
         den    = (128'd1 << 32) + {64'd0, e};
         rom[k] = 16'(const_div(128'd2 * num + den, 128'd2 * den));
         prod   = {64'd0, e} * {64'd0, stp};
         e      = 64'((prod + (128'd1 << 31)) >> 32);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/amb_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module amb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/amb_tanh_rom.sv =====
// ----------------------------------------------------------------------------
// soft limiter table
// tanh curve in 512 bins with registered read data
// ----------------------------------------------------------------------------
module amb_tanh_rom (
   input  logic                        clock,
   input  logic [amb_pkg::TANH_AW-1:0] addr,
   output logic [15:0]                 data
);

   localparam amb_pkg::tanh_rom_type ROM = amb_pkg::build_tanh();

   logic [15:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= ROM[addr];
   end

   assign data = data_ff;

endmodule

// ===== rtl/amb_arith.sv =====
// ----------------------------------------------------------------------------
// shared arithmetic unit
// multiplier, two-bit restoring divide step and square root step
// ----------------------------------------------------------------------------
module amb_arith (
   input  logic signed [32:0]       mul_a,
   input  logic signed [17:0]       mul_b,
   output logic signed [50:0]       mul_p,
   input  amb_pkg::div_state_type   div_cur,
   input  logic [23:0]              div_den,
   output amb_pkg::div_state_type   div_nxt,
   input  amb_pkg::sqrt_state_type  sq_cur,
   output amb_pkg::sqrt_state_type  sq_nxt
);

   logic [24:0] part0;
   logic [24:0] part1;
   logic [23:0] rem0;
   logic        bit0;
   logic        bit1;
   logic [63:0] trial;

   assign mul_p = 51'(mul_a) * 51'(mul_b);

   always_comb begin
      part0 = {div_cur.rem, div_cur.quo[63]};
      bit0  = part0 >= {1'b0, div_den};
      rem0  = bit0 ? 24'(part0 - {1'b0, div_den}) : part0[23:0];
      part1 = {rem0, div_cur.quo[62]};
      bit1  = part1 >= {1'b0, div_den};
      div_nxt.rem = bit1 ? 24'(part1 - {1'b0, div_den}) : part1[23:0];
      div_nxt.quo = {div_cur.quo[61:0], bit0, bit1};
   end

   always_comb begin
      trial      = sq_cur.r + sq_cur.one;
      sq_nxt.one = sq_cur.one >> 2;
      if (sq_cur.x >= trial) begin
         sq_nxt.x = sq_cur.x - trial;
         sq_nxt.r = (sq_cur.r >> 1) + sq_cur.one;
      end else begin
         sq_nxt.x = sq_cur.x;
         sq_nxt.r = sq_cur.r >> 1;
      end
   end

endmodule

// ===== rtl/audio_mix_bus_with_fades_and_meters_top.sv =====
// ----------------------------------------------------------------------------
// mix bus with fades and meters
// fixed point mix buffer with fade envelope, soft limiter and channel meters
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  req      start / busy              operation, frame, channel, sample, ...
//  rsp      rsp_valid (one cycle)     out_sample, was_clipped, peak, rms, clips
//  csr      csr_write_enable          csr_index, csr_write_data
//
//  accumulate runs the fade divides, two quotient bits a cycle per fade divide, then multiplies and writes
//  read out passes through the buffer read, multiplier and tanh table
//  report runs a 64-bit mean divide then a 32-step square root
//  out of range read out or report answers in the cycle after start
//  reset and clear sweep all 32768 buffer entries, one a cycle, busy meanwhile
//  the receiver cannot stall: each result beat is shown for one cycle
// ----------------------------------------------------------------------------
module audio_mix_bus_with_fades_and_meters_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [11:0]           req_frame,
   input  logic [2:0]            req_channel,
   input  logic signed [15:0]    req_sample,
   input  logic [15:0]           req_channel_gain,
   input  logic [23:0]           req_source_position,
   input  logic [23:0]           req_source_length,
   input  logic [23:0]           req_fade_in_length,
   input  logic [23:0]           req_fade_out_length,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_out_sample,
   output logic                  rsp_was_clipped,
   output logic [15:0]           rsp_channel_peak,
   output logic [15:0]           rsp_channel_rms,
   output logic [31:0]           rsp_clipped_total,
   input  logic                  csr_write_enable,
   input  logic [amb_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [amb_pkg::CSR_W-1:0]     csr_write_data
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_FIN, ST_FOUT, ST_ENV, ST_SG, ST_SGE, ST_WR,
      ST_RD_WAIT, ST_RD_MUL, ST_RD_ABS, ST_RD_ROM, ST_RD_SQ, ST_RD_DONE,
      ST_RP_SETUP, ST_RP_DIV, ST_RP_SQRT
   } state_type;

   state_type state_ff;

   logic [3:0]  channel_count_ff;
   logic [12:0] frame_count_ff;
   logic [15:0] master_gain_ff;
   logic        limiter_enable_ff;

   logic [amb_pkg::ADDR_W-1:0] addr_ff;
   logic [amb_pkg::ADDR_W-1:0] clr_cnt_ff;
   logic [amb_pkg::CH_W-1:0]   ch_ff;
   logic signed [15:0]         sample_ff;
   logic [15:0]                gain_ff;
   logic [23:0]                pos_ff;
   logic [23:0]                len_ff;
   logic [23:0]                fout_ff;
   logic                       fin_run_ff;
   logic                       fout_run_ff;
   logic [16:0]                rin_ff;
   logic [16:0]                rout_ff;
   logic [16:0]                env_ff;
   logic signed [50:0]         prod_ff;
   logic [35:0]                mag_ff;
   logic                       neg_ff;
   logic [14:0]                om_ff;
   logic [amb_pkg::CNT_W-1:0]  cnt_ff;
   logic [23:0]                den_ff;
   amb_pkg::div_state_type     div_ff;
   amb_pkg::sqrt_state_type    sq_ff;
   logic [15:0]                peak_ff [amb_pkg::MAX_CHANNELS];
   logic [63:0]                sum_ff [amb_pkg::MAX_CHANNELS];
   logic [31:0]                clip_ff;

   logic                       rsp_valid_ff;
   logic signed [15:0]         rsp_out_sample_ff;
   logic                       rsp_was_clipped_ff;
   logic [15:0]                rsp_channel_peak_ff;
   logic [15:0]                rsp_channel_rms_ff;
   logic [31:0]                rsp_clipped_total_ff;

   logic                       accept;
   logic                       addr_ok;
   logic                       ch_ok;
   logic signed [32:0]         mul_a;
   logic signed [17:0]         mul_b;
   logic signed [50:0]         mul_p;
   amb_pkg::div_state_type     div_nxt;
   amb_pkg::sqrt_state_type    sq_nxt;
   logic [31:0]                entry;
   logic                       wr_en;
   logic [amb_pkg::ADDR_W-1:0] wr_addr;
   logic [31:0]                wr_data;
   logic signed [33:0]         acc_sum;
   logic [31:0]                acc_sat;
   logic [38:0]                v_mag;
   logic [15:0]                rom_data;
   logic [14:0]                om;
   logic                       clip;
   logic [64:0]                sum_add;
   logic [15:0]                peak_new;
   logic [31:0]                clip_new;
   logic [23:0]                rem_out;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign ch_ok   = {1'b0, req_channel} < amb_pkg::eff_channels(channel_count_ff);
   assign addr_ok = ch_ok &&
                    ({1'b0, req_frame} < amb_pkg::eff_frames(frame_count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff  <= 4'd2;
         frame_count_ff    <= 13'(amb_pkg::MAX_FRAMES);
         master_gain_ff    <= 16'd4096;
         limiter_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            amb_pkg::REG_CHANNEL_COUNT:  channel_count_ff  <= csr_write_data[3:0];
            amb_pkg::REG_FRAME_COUNT:    frame_count_ff    <= csr_write_data[12:0];
            amb_pkg::REG_MASTER_GAIN:    master_gain_ff    <= csr_write_data;
            amb_pkg::REG_LIMITER_ENABLE: limiter_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ENV: begin
            mul_a = {16'd0, rin_ff};
            mul_b = {1'b0, rout_ff};
         end
         ST_SG: begin
            mul_a = {{17{sample_ff[15]}}, sample_ff};
            mul_b = {2'b0, gain_ff};
         end
         ST_SGE: begin
            mul_a = prod_ff[32:0];
            mul_b = {1'b0, env_ff};
         end
         ST_RD_MUL: begin
            mul_a = {entry[31], entry};
            mul_b = {2'b0, master_gain_ff};
         end
         ST_RD_SQ: begin
            mul_a = {18'd0, om};
            mul_b = {3'd0, om};
         end
         default: ;
      endcase
   end

   amb_arith u_arith (
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_p   (mul_p),
      .div_cur (div_ff),
      .div_den (den_ff),
      .div_nxt (div_nxt),
      .sq_cur  (sq_ff),
      .sq_nxt  (sq_nxt)
   );

   assign wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WR);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : addr_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? 32'd0 : acc_sat;

   amb_ram #(
      .WIDTH (amb_pkg::BUF_W),
      .DEPTH (amb_pkg::BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (entry)
   );

   amb_tanh_rom u_tanh (
      .clock (clock),
      .addr  (mag_ff[17:9]),
      .data  (rom_data)
   );

   always_comb begin
      acc_sum = {{2{entry[31]}}, entry} + {{11{prod_ff[50]}}, prod_ff[50:28]};
      if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111) acc_sat = acc_sum[31:0];
      else if (acc_sum[33]) acc_sat = 32'h8000_0000;
      else acc_sat = 32'h7fff_ffff;

      v_mag = prod_ff[50] ? 39'(39'd0 - prod_ff[50:12]) : prod_ff[50:12];

      if (limiter_enable_ff) om = (mag_ff[35:18] == '0) ? rom_data[14:0] : 15'h7fff;
      else om = (mag_ff > 36'd32767) ? 15'h7fff : mag_ff[14:0];

      clip     = mag_ff > 36'd32768;
      sum_add  = {1'b0, sum_ff[ch_ff]} + {35'd0, prod_ff[29:0]};
      peak_new = ({1'b0, om_ff} > peak_ff[ch_ff]) ? {1'b0, om_ff} : peak_ff[ch_ff];
      clip_new = (clip && clip_ff != 32'hffff_ffff) ? clip_ff + 32'd1 : clip_ff;
      rem_out  = (pos_ff < len_ff) ? len_ff - pos_ff : 24'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= '0;
         for (int i = 0; i < amb_pkg::MAX_CHANNELS; i++) begin
            peak_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         prod_ff      <= mul_p;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  addr_ff   <= {req_frame, req_channel};
                  ch_ff     <= req_channel;
                  sample_ff <= req_sample;
                  gain_ff   <= req_channel_gain;
                  pos_ff    <= req_source_position;
                  len_ff    <= req_source_length;
                  fout_ff   <= req_fade_out_length;
                  cnt_ff    <= '0;
                  case (req_operation)
                     amb_pkg::OP_CLEAR: begin
                        clr_cnt_ff <= '0;
                        clip_ff    <= '0;
                        for (int i = 0; i < amb_pkg::MAX_CHANNELS; i++) begin
                           peak_ff[i] <= '0;
                           sum_ff[i]  <= '0;
                        end
                        state_ff <= ST_CLEAR;
                     end
                     amb_pkg::OP_ACC: begin
                        fin_run_ff <= (req_fade_in_length != 24'd0) &&
                                      (req_source_position < req_fade_in_length);
                        div_ff.rem <= req_source_position;
                        div_ff.quo <= '0;
                        den_ff     <= req_fade_in_length;
                        if (addr_ok) state_ff <= ST_FIN;
                     end
                     amb_pkg::OP_READ: begin
                        if (addr_ok) begin
                           state_ff <= ST_RD_WAIT;
                        end else begin
                           rsp_valid_ff         <= 1'b1;
                           rsp_out_sample_ff    <= '0;
                           rsp_was_clipped_ff   <= 1'b0;
                           rsp_channel_peak_ff  <= '0;
                           rsp_channel_rms_ff   <= '0;
                           rsp_clipped_total_ff <= clip_ff;
                        end
                     end
                     amb_pkg::OP_REPORT: begin
                        if (ch_ok) begin
                           state_ff <= ST_RP_SETUP;
                        end else begin
                           rsp_valid_ff         <= 1'b1;
                           rsp_out_sample_ff    <= '0;
                           rsp_was_clipped_ff   <= 1'b0;
                           rsp_channel_peak_ff  <= '0;
                           rsp_channel_rms_ff   <= '0;
                           rsp_clipped_total_ff <= clip_ff;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_FIN: begin
               if (fin_run_ff && cnt_ff != amb_pkg::CNT_W'(amb_pkg::FADE_STEPS)) begin
                  div_ff <= div_nxt;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  rin_ff      <= fin_run_ff ? {1'b0, div_ff.quo[15:0]} : 17'h10000;
                  fout_run_ff <= (fout_ff != 24'd0) && (rem_out < fout_ff);
                  div_ff.rem  <= rem_out;
                  div_ff.quo  <= '0;
                  den_ff      <= fout_ff;
                  cnt_ff      <= '0;
                  state_ff    <= ST_FOUT;
               end
            end
            ST_FOUT: begin
               if (fout_run_ff && cnt_ff != amb_pkg::CNT_W'(amb_pkg::FADE_STEPS)) begin
                  div_ff <= div_nxt;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  rout_ff  <= fout_run_ff ? {1'b0, div_ff.quo[15:0]} : 17'h10000;
                  state_ff <= ST_ENV;
               end
            end
            ST_ENV: state_ff <= ST_SG;
            ST_SG: begin
               env_ff   <= prod_ff[32:16];
               state_ff <= ST_SGE;
            end
            ST_SGE: state_ff <= ST_WR;
            ST_WR: state_ff <= ST_IDLE;
            ST_RD_WAIT: state_ff <= ST_RD_MUL;
            ST_RD_MUL: state_ff <= ST_RD_ABS;
            ST_RD_ABS: begin
               mag_ff   <= v_mag[35:0];
               neg_ff   <= prod_ff[50];
               state_ff <= ST_RD_ROM;
            end
            ST_RD_ROM: state_ff <= ST_RD_SQ;
            ST_RD_SQ: begin
               om_ff    <= om;
               state_ff <= ST_RD_DONE;
            end
            ST_RD_DONE: begin
               clip_ff        <= clip_new;
               peak_ff[ch_ff] <= peak_new;
               sum_ff[ch_ff]  <= sum_add[64] ? 64'hffff_ffff_ffff_ffff : sum_add[63:0];
               rsp_valid_ff         <= 1'b1;
               rsp_out_sample_ff    <= neg_ff ? 16'(16'd0 - {1'b0, om_ff}) : {1'b0, om_ff};
               rsp_was_clipped_ff   <= clip;
               rsp_channel_peak_ff  <= peak_new;
               rsp_channel_rms_ff   <= '0;
               rsp_clipped_total_ff <= clip_new;
               state_ff             <= ST_IDLE;
            end
            ST_RP_SETUP: begin
               div_ff.rem <= '0;
               div_ff.quo <= sum_ff[ch_ff];
               den_ff     <= {11'd0, amb_pkg::eff_frames(frame_count_ff)};
               cnt_ff     <= '0;
               state_ff   <= ST_RP_DIV;
            end
            ST_RP_DIV: begin
               if (cnt_ff != amb_pkg::CNT_W'(amb_pkg::RMS_STEPS)) begin
                  div_ff <= div_nxt;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  sq_ff.x   <= div_ff.quo;
                  sq_ff.r   <= '0;
                  sq_ff.one <= 64'd1 << 62;
                  cnt_ff    <= '0;
                  state_ff  <= ST_RP_SQRT;
               end
            end
            ST_RP_SQRT: begin
               if (cnt_ff != amb_pkg::CNT_W'(amb_pkg::SQRT_STEPS)) begin
                  sq_ff  <= sq_nxt;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_out_sample_ff    <= '0;
                  rsp_was_clipped_ff   <= 1'b0;
                  rsp_channel_peak_ff  <= peak_ff[ch_ff];
                  rsp_channel_rms_ff   <= sq_ff.r[15:0];
                  rsp_clipped_total_ff <= clip_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_sample    = rsp_out_sample_ff;
   assign rsp_was_clipped   = rsp_was_clipped_ff;
   assign rsp_channel_peak  = rsp_channel_peak_ff;
   assign rsp_channel_rms   = rsp_channel_rms_ff;
   assign rsp_clipped_total = rsp_clipped_total_ff;

endmodule

// ===== rtl/amb_checker.sv =====
// ----------------------------------------------------------------------------
// mix bus checker
// port level properties of the mix bus, bound to the top level
// ----------------------------------------------------------------------------
`include "audio_mix_bus_with_fades_and_meters_top_assert.svh"

module amb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [1:0]            req_operation,
   input logic                  rsp_valid,
   input logic signed [15:0]    rsp_out_sample,
   input logic                  rsp_was_clipped,
   input logic [15:0]           rsp_channel_rms,
   input logic [31:0]           rsp_clipped_total
);

   `AMB_ASSERT_NEXT(a_clear_busy, start && !busy && req_operation == amb_pkg::OP_CLEAR, busy, "clear beat did not start a sweep")
   `AMB_ASSERT_NEXT(a_acc_silent, start && !busy && req_operation == amb_pkg::OP_ACC, !rsp_valid, "accumulate produced a result beat")
   `AMB_ASSERT_SAME(a_rms_only, rsp_valid && rsp_channel_rms != 16'd0, rsp_out_sample == 16'sd0 && !rsp_was_clipped, "report beat carries sample data")
   `AMB_ASSERT_SAME(a_clip_count, rsp_valid && rsp_was_clipped, rsp_clipped_total != 32'd0, "clip flagged with zero clip total")

endmodule

bind audio_mix_bus_with_fades_and_meters_top amb_checker u_amb_checker (.*);
